FILE: rtl/core/ipck_pkg.sv
// ----------------------------------------------------------------------------
// ipck_pkg
// Shared types for the IPv4/TCP checksum engine core.
// ----------------------------------------------------------------------------
package ipck_pkg;

  localparam int WORD_W = 16;

  // one input word as held in the input stage
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              sop;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic              length_error;
    logic [WORD_W-1:0] tcp_csum;
    logic [WORD_W-1:0] ip_csum;
  } csum_result_t;

endpackage

FILE: rtl/core/ipck_in_stage.sv
// ----------------------------------------------------------------------------
// ipck_in_stage
// Input register for packet words; loads when empty or when the held word moves on.
// ----------------------------------------------------------------------------
module ipck_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ipck_pkg::in_word_t in_data,
  input  logic              advance,
  output logic              held_valid,
  output ipck_pkg::in_word_t held_data
);
  import ipck_pkg::*;

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_data <= in_data;
    end
  end

endmodule

FILE: rtl/core/ipck_accum.sv
// ----------------------------------------------------------------------------
// ipck_accum
// Packet state and running ones' complement sums; one word per cycle while fire is high.
// ----------------------------------------------------------------------------
module ipck_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  ipck_pkg::in_word_t      in_data,
  output logic                    res_valid,
  output ipck_pkg::csum_result_t  res
);
  import ipck_pkg::*;

  localparam logic [14:0] CSUM_WORD_IP  = 15'd5;
  localparam logic [5:0]  CSUM_WORD_TCP = 6'd8;
  localparam logic [14:0] ADDR_FIRST    = 15'd6;
  localparam logic [14:0] ADDR_LAST     = 15'd9;
  localparam logic [4:0]  MIN_HDR_WORDS = 5'd10;
  localparam logic [15:0] PROTO_TCP     = 16'd6;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  logic [14:0] word_count, word_count_next;
  logic [15:0] header_sum, header_sum_next;
  logic [15:0] segment_sum, segment_sum_next;
  logic [4:0]  header_words, header_words_next;
  logic [15:0] packet_length, packet_length_next;
  logic        in_packet, in_packet_next;

  logic [14:0] idx;
  logic [15:0] last_w;
  logic [14:0] last_idx;
  logic [15:0] hdr_bytes;
  logic [5:0]  tcp_idx;
  logic [15:0] w;
  logic        is_last;

  assign idx       = word_count + 15'd1;
  assign last_w    = packet_length - 16'd1;
  assign last_idx  = last_w[15:1];
  assign hdr_bytes = {10'd0, header_words, 1'b0};
  assign tcp_idx   = {1'b0, header_words} + CSUM_WORD_TCP;
  assign is_last   = (idx == last_idx);

  always_comb begin
    word_count_next    = word_count;
    header_sum_next    = header_sum;
    segment_sum_next   = segment_sum;
    header_words_next  = header_words;
    packet_length_next = packet_length;
    in_packet_next     = in_packet;
    res_valid          = 1'b0;
    res                = '0;
    w                  = in_data.word;
    if (fire) begin
      if (in_data.sop) begin
        word_count_next    = '0;
        header_words_next  = {in_data.word[11:8], 1'b0};
        header_sum_next    = in_data.word;
        segment_sum_next   = '0;
        packet_length_next = '0;
        in_packet_next     = 1'b1;
      end else if (in_packet) begin
        word_count_next = idx;
        if (idx == 15'd1) begin
          packet_length_next = in_data.word;
          if (header_words < MIN_HDR_WORDS || in_data.word < hdr_bytes) begin
            in_packet_next   = 1'b0;
            res_valid        = 1'b1;
            res.length_error = 1'b1;
          end else begin
            header_sum_next  = oc_add(header_sum, in_data.word);
            segment_sum_next = oc_add(oc_add(segment_sum, PROTO_TCP),
                                      in_data.word - hdr_bytes);
          end
        end else begin
          if (is_last && packet_length[0]) begin
            w = {in_data.word[15:8], 8'd0};
          end
          if (idx < {10'd0, header_words}) begin
            if (idx != CSUM_WORD_IP) begin
              header_sum_next = oc_add(header_sum, w);
            end
            if (idx >= ADDR_FIRST && idx <= ADDR_LAST) begin
              segment_sum_next = oc_add(segment_sum, w);
            end
          end else if (idx != {9'd0, tcp_idx}) begin
            segment_sum_next = oc_add(segment_sum, w);
          end
          if (is_last) begin
            in_packet_next   = 1'b0;
            res_valid        = 1'b1;
            res.ip_csum      = ~header_sum_next;
            res.tcp_csum     = ~segment_sum_next;
            res.length_error = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      header_sum    <= '0;
      segment_sum   <= '0;
      header_words  <= '0;
      packet_length <= '0;
      in_packet     <= 1'b0;
    end else begin
      word_count    <= word_count_next;
      header_sum    <= header_sum_next;
      segment_sum   <= segment_sum_next;
      header_words  <= header_words_next;
      packet_length <= packet_length_next;
      in_packet     <= in_packet_next;
    end
  end

  a_closed_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !in_packet)
    else $error("packet still open after its result");

  a_error_zero_sums: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.length_error) |-> (res.ip_csum == 16'd0 && res.tcp_csum == 16'd0))
    else $error("length error result carries checksums");

  a_length_checked: assert property (@(posedge clk) disable iff (rst)
    (in_packet && word_count != 15'd0) |-> (packet_length >= 16'd20))
    else $error("open packet past word 1 with short length");

  a_header_checked: assert property (@(posedge clk) disable iff (rst)
    (in_packet && word_count != 15'd0) |-> (header_words >= MIN_HDR_WORDS))
    else $error("open packet past word 1 with short header");

endmodule

FILE: rtl/core/ipck_out_stage.sv
// ----------------------------------------------------------------------------
// ipck_out_stage
// Result register on the master side; frees the pipeline when taken.
// ----------------------------------------------------------------------------
module ipck_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  ipck_pkg::csum_result_t res,
  output logic                   advance,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output ipck_pkg::csum_result_t out_res
);
  import ipck_pkg::*;

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

FILE: rtl/core/ipv4_tcp_checksum_engine_core.sv
// ----------------------------------------------------------------------------
// ipv4_tcp_checksum_engine_core
// IPv4 header and TCP segment checksum engine over a 16-bit word stream.
// ----------------------------------------------------------------------------
// Result path: after the packet's last word (or word 1 on a length error) is accepted,
//   it passes the input register, then the output register, before m_tvalid is raised.
// Throughput: 1 word per cycle, set by the end-around-carry adders of the
//   accumulate stage; a waiting result stalls input only once both stages fill.
// Reset: synchronous, clears the sums, packet state and both valid flags.
// ----------------------------------------------------------------------------
module ipv4_tcp_checksum_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] pkt_word
  input  logic [0:0]  s_tuser,   // [0] start_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] ip_header_checksum, [31:16] tcp_segment_checksum
  output logic [0:0]  m_tuser    // [0] length_error
);
  import ipck_pkg::*;

  in_word_t     in_data;
  in_word_t     held_data;
  logic         held_valid;
  logic         advance;
  logic         fire;
  logic         res_valid;
  csum_result_t res;
  csum_result_t out_res;

  assign in_data      = {s_tdata, s_tuser[0]};
  assign fire         = held_valid && advance;

  ipck_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  ipck_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_data   (held_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ipck_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_res  (out_res)
  );

  assign m_tdata    = {out_res.tcp_csum, out_res.ip_csum};
  assign m_tuser[0] = out_res.length_error;

endmodule
